/* rtl/core/spo_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spo_pkg: shared definitions for the stereo panned oscillator
// Default sizes, register indexes, wave shape codes, sequencer states and the
// quarter-wave sine entry generator used to fill the sine ROM at elaboration.
// ----------------------------------------------------------------------------
package spo_pkg;

   localparam int unsigned PHASE_BITS_DEF      = 32;
   localparam int unsigned SINE_TABLE_BITS_DEF = 10;
   localparam int unsigned SAMPLE_BITS_DEF     = 16;

   // Configuration port.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_AMPLITUDE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAN        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAVE_SHAPE = 3'd4;

   // Register values after reset.
   localparam logic        ENABLE_RST     = 1'b1;
   localparam logic [31:0] PHASE_STEP_RST = 32'd39370534;
   localparam logic [15:0] AMPLITUDE_RST  = 16'd32768;
   localparam logic [15:0] PAN_RST        = 16'd0;
   localparam logic [2:0]  WAVE_SHAPE_RST = 3'd0;
   localparam logic [31:0] NOISE_SEED_RST = 32'd1;

   // Wave shapes.
   localparam logic [2:0] WAVE_SINE     = 3'd0;
   localparam logic [2:0] WAVE_SQUARE   = 3'd1;
   localparam logic [2:0] WAVE_SAWTOOTH = 3'd2;
   localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
   localparam logic [2:0] WAVE_NOISE    = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SINE,
      S_GAIN_ADDR,
      S_GAIN_MUL,
      S_DIGIT,
      S_ACC,
      S_OUT
   } spo_state_type;

   // pi/2 in Q30 and the Taylor series denominators (2k)(2k+1).
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] TAYLOR_DIV [1:8] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
   };

   // Entry i of a quarter-wave table with 2^tbits steps, in sbits-1 fraction
   // bits, clamped to [0, 1.0]. Evaluated only at elaboration.
   function automatic logic [63:0] sine_entry(input int unsigned i,
                                              input int unsigned tbits,
                                              input int unsigned sbits);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        v;
      logic [63:0]        one;
      logic signed [63:0] sum;
      x    = (64'(i) * HALF_PI_Q30) >> tbits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (int unsigned k = 1; k <= 8; k++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[k];
         if (k % 2 == 1) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      v   = ((unsigned'(sum) << (sbits - 1)) + (64'd1 << 29)) >> 30;
      one = 64'd1 << (sbits - 1);
      if (v > one) begin
         v = one;
      end
      return v;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/stereo_panned_oscillator_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_panned_oscillator_top: oscillator added to a stereo mix with panning
// The one shared multiplier forms 1+D products per channel, where
// D = ceil((SAMPLE_BITS+15)/16) (D = 2 by default); a disabled frame skips
// them and goes straight to the output step. A new frame is taken only once
// the last has been passed on to the result register.
// Synchronous reset restores the register defaults, zero phase and seed 1.
// ----------------------------------------------------------------------------
module stereo_panned_oscillator_top #(
   parameter int unsigned PHASE_BITS      = spo_pkg::PHASE_BITS_DEF,
   parameter int unsigned SINE_TABLE_BITS = spo_pkg::SINE_TABLE_BITS_DEF,
   parameter int unsigned SAMPLE_BITS     = spo_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Input channel: one sample frame of the mix.
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic signed [15:0]                 req_mix_left,
   input  wire logic signed [15:0]                 req_mix_right,
   input  wire logic                               req_block_last,
   // Result channel.
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [15:0]                      rsp_left,
   output logic signed [15:0]                      rsp_right,
   output logic                                    rsp_last,
   // Configuration write port.
   input  wire logic                               csr_write_enable,
   input  wire logic [spo_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [spo_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import spo_pkg::*;

   // ------------------------------------------------------------------------
   // Sizes. The sample carries SFRAC fraction bits and may reach +1.0, so it
   // needs SAMPLE_BITS+1 bits signed. The sample is multiplied by the product
   // of amplitude and pan gain (AG), which is split into 16-bit digits so
   // that the shared multiplier never exceeds (SAMPLE_BITS+1) x 17 bits.
   // ------------------------------------------------------------------------
   localparam int unsigned SFRAC   = SAMPLE_BITS - 1;
   localparam int unsigned SMP_W   = SAMPLE_BITS + 1;
   localparam int unsigned MUL_W   = SMP_W + 17;
   localparam int unsigned AG_W    = SAMPLE_BITS + 15;
   localparam int unsigned DIGITS  = (AG_W + 15) / 16;
   localparam int unsigned DIG_W   = $clog2(DIGITS);
   localparam int unsigned AG_PADW = DIGITS * 16;
   localparam int unsigned ACC_W   = 2 * SFRAC + 17;
   localparam int unsigned TAB_N   = 1 << SINE_TABLE_BITS;
   localparam int unsigned ROM_AW  = SINE_TABLE_BITS + 1;
   localparam int unsigned ONE_INT = 1 << SFRAC;

   localparam logic signed [SMP_W-1:0] ONE_S     = SMP_W'(ONE_INT);
   localparam logic signed [SMP_W:0]   TRI_ONE   = (SMP_W + 1)'(ONE_INT);
   localparam logic signed [SMP_W:0]   TRI_THREE = (SMP_W + 1)'(3 * ONE_INT);
   localparam logic [ACC_W-1:0]        ACC_RND   = ACC_W'(1) << (2 * SFRAC - 1);
   localparam logic [DIG_W-1:0]        DIG_LAST  = DIG_W'(DIGITS - 1);
   localparam logic [ROM_AW-1:0]       ROM_TOP   = ROM_AW'(TAB_N);

   // ------------------------------------------------------------------------
   // Quarter-wave sine ROM, 2^SINE_TABLE_BITS+1 entries, filled at
   // elaboration and read through a registered port. It serves both the sine
   // wave and the two pan gains.
   // ------------------------------------------------------------------------
   typedef logic [SAMPLE_BITS-1:0] rom_type [0:TAB_N];

   function automatic rom_type build_rom();
      rom_type r;
      for (int unsigned i = 0; i <= TAB_N; i++) begin
         r[i] = SAMPLE_BITS'(sine_entry(i, SINE_TABLE_BITS, SAMPLE_BITS));
      end
      return r;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      if (v[17:15] == 3'b000 || v[17:15] == 3'b111) begin
         return v[15:0];
      end
      return v[17] ? 16'sh8000 : 16'sh7fff;
   endfunction

   // Configuration registers.
   logic                     enable_ff;
   logic [31:0]              phase_step_ff;
   logic [15:0]              amplitude_ff;
   logic signed [15:0]       pan_ff;
   logic [2:0]               wave_shape_ff;

   // Oscillator state.
   logic [PHASE_BITS-1:0]    phase_ff;
   logic [31:0]              noise_seed_ff;

   // Sequencer and datapath.
   spo_state_type            state_ff, state_in;
   logic                     chan_ff;
   logic [DIG_W-1:0]         dig_ff;
   logic                     prod_vld_ff;
   logic [DIG_W-1:0]         prod_k_ff;
   logic signed [MUL_W-1:0]  prod_ff;
   logic [31:0]              u_ff;
   logic signed [SMP_W-1:0]  smp_ff;
   logic [AG_W-1:0]          ag_ff;
   logic signed [ACC_W-1:0]  acc_l_ff;
   logic signed [ACC_W-1:0]  acc_r_ff;
   logic signed [15:0]       mix_l_ff;
   logic signed [15:0]       mix_r_ff;
   logic                     last_ff;
   logic [SAMPLE_BITS-1:0]   rom_data_ff;

   // Result register.
   logic                     rsp_valid_ff;
   logic signed [15:0]       rsp_left_ff;
   logic signed [15:0]       rsp_right_ff;
   logic                     rsp_last_ff;

   // Combinational signals.
   logic                     req_accept;
   logic                     out_free;
   logic [31:0]              u_cur;
   logic [31:0]              noise1, noise2, noise3;
   logic signed [SMP_W:0]    tri_full;
   logic signed [SMP_W-1:0]  wave_smp;
   logic signed [SMP_W-1:0]  sine_smp;
   logic [15:0]              pan_biased;
   logic [SINE_TABLE_BITS-1:0] pan_idx;
   logic [SINE_TABLE_BITS-1:0] sine_idx;
   logic [ROM_AW-1:0]        rom_addr;
   logic [AG_PADW-1:0]       ag_pad;
   logic [15:0]              ag_digit;
   logic signed [SMP_W-1:0]  mul_a;
   logic signed [16:0]       mul_b;
   logic signed [MUL_W-1:0]  mul_out;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  addend;
   logic signed [17:0]       sum_l, sum_r;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // The waveforms work from the top 32 bits of the phase; a narrower phase is
   // left-aligned into them.
   assign u_cur = 32'({phase_ff, 32'd0} >> PHASE_BITS);

   // xorshift32 step; only committed for an enabled noise frame.
   assign noise1 = noise_seed_ff ^ (noise_seed_ff << 13);
   assign noise2 = noise1 ^ (noise1 >> 17);
   assign noise3 = noise2 ^ (noise2 << 5);

   // The triangle is formed one bit wider and fits the sample width after.
   assign tri_full = u_cur[31] ? (TRI_THREE - signed'({1'b0, u_cur[31 -: SMP_W]}))
                               : (signed'({1'b0, u_cur[31 -: SMP_W]}) - TRI_ONE);

   // Sample for every shape but sine, formed at the accepting edge. The sine
   // sample replaces it once the ROM has been read.
   always_comb begin
      case (wave_shape_ff)
         WAVE_SQUARE:   wave_smp = u_cur[31] ? -ONE_S : ONE_S;
         WAVE_SAWTOOTH: wave_smp = signed'({1'b0, u_cur[31 -: SAMPLE_BITS]}) - ONE_S;
         WAVE_TRIANGLE: wave_smp = tri_full[SMP_W-1:0];
         WAVE_NOISE:    wave_smp = {noise3[31], noise3[31 -: SAMPLE_BITS]};
         default:       wave_smp = '0;
      endcase
   end

   // Quadrants 1 and 3 read the table backwards; the second half is negated.
   assign sine_idx = u_ff[29 -: SINE_TABLE_BITS];
   assign sine_smp = u_ff[31] ? -signed'({1'b0, rom_data_ff})
                              : signed'({1'b0, rom_data_ff});

   // Pan position moved to an unsigned index; the left gain reads the table
   // from the top end, the right gain from the bottom.
   assign pan_biased = {~pan_ff[15], pan_ff[14:0]};
   assign pan_idx    = pan_biased[15 -: SINE_TABLE_BITS];

   always_comb begin
      if (state_ff == S_GAIN_ADDR) begin
         rom_addr = chan_ff ? {1'b0, pan_idx} : (ROM_TOP - {1'b0, pan_idx});
      end else begin
         rom_addr = u_ff[30] ? (ROM_TOP - {1'b0, sine_idx}) : {1'b0, sine_idx};
      end
   end

   // ------------------------------------------------------------------------
   // Shared multiplier. In S_GAIN_MUL it forms gain x amplitude; in S_DIGIT it
   // forms sample x one 16-bit digit of that product.
   // ------------------------------------------------------------------------
   assign ag_pad   = AG_PADW'(ag_ff);
   assign ag_digit = ag_pad[{dig_ff, 4'b0000} +: 16];

   always_comb begin
      if (state_ff == S_GAIN_MUL) begin
         mul_a = signed'({1'b0, rom_data_ff});
         mul_b = signed'({1'b0, amplitude_ff});
      end else begin
         mul_a = smp_ff;
         mul_b = signed'({1'b0, ag_digit});
      end
   end

   assign mul_out  = mul_a * mul_b;
   assign prod_ext = {{(ACC_W - MUL_W){prod_ff[MUL_W-1]}}, prod_ff};
   assign addend   = prod_ext << {prod_k_ff, 4'b0000};

   // The accumulators start at half an output step, so dropping the 2*SFRAC
   // fraction bits rounds half up.
   assign sum_l = {{2{mix_l_ff[15]}}, mix_l_ff} + {acc_l_ff[ACC_W-1], acc_l_ff[ACC_W-1 -: 17]};
   assign sum_r = {{2{mix_r_ff[15]}}, mix_r_ff} + {acc_r_ff[ACC_W-1], acc_r_ff[ACC_W-1 -: 17]};

   // ------------------------------------------------------------------------
   // Sequencer: unless disabled, optional sine read, per channel a gain read,
   // the gain product, one product per digit, a final accumulate; then the result.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (!enable_ff) begin
                  state_in = S_OUT;
               end else if (wave_shape_ff == WAVE_SINE) begin
                  state_in = S_SINE;
               end else begin
                  state_in = S_GAIN_ADDR;
               end
            end
         end
         S_SINE:      state_in = S_GAIN_ADDR;
         S_GAIN_ADDR: state_in = S_GAIN_MUL;
         S_GAIN_MUL:  state_in = S_DIGIT;
         S_DIGIT: begin
            if (dig_ff == DIG_LAST) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            state_in = chan_ff ? S_OUT : S_GAIN_ADDR;
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control counters and the product pipeline flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff     <= 1'b0;
         dig_ff      <= '0;
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= (state_ff == S_DIGIT);
         if (req_accept) begin
            chan_ff <= 1'b0;
         end else if (state_ff == S_ACC) begin
            chan_ff <= 1'b1;
         end
         if (state_ff == S_DIGIT) begin
            dig_ff <= (dig_ff == DIG_LAST) ? '0 : dig_ff + 1'b1;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rom_data_ff <= SINE_ROM[rom_addr];
      if (req_accept) begin
         u_ff     <= u_cur;
         smp_ff   <= wave_smp;
         mix_l_ff <= req_mix_left;
         mix_r_ff <= req_mix_right;
         last_ff  <= req_block_last;
         acc_l_ff <= ACC_RND;
         acc_r_ff <= ACC_RND;
      end else if (prod_vld_ff) begin
         if (chan_ff) begin
            acc_r_ff <= acc_r_ff + addend;
         end else begin
            acc_l_ff <= acc_l_ff + addend;
         end
      end
      if (state_ff == S_GAIN_ADDR && !chan_ff && wave_shape_ff == WAVE_SINE) begin
         smp_ff <= sine_smp;
      end
      if (state_ff == S_GAIN_MUL) begin
         ag_ff <= mul_out[AG_W-1:0];
      end
      if (state_ff == S_DIGIT) begin
         prod_ff   <= mul_out;
         prod_k_ff <= dig_ff;
      end
   end

   // Phase and noise seed advance only for an enabled frame.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         noise_seed_ff <= NOISE_SEED_RST;
      end else if (req_accept && enable_ff) begin
         phase_ff <= phase_ff + PHASE_BITS'(phase_step_ff);
         if (wave_shape_ff == WAVE_NOISE) begin
            noise_seed_ff <= noise3;
         end
      end
   end

   // Configuration writes; an index beyond the register list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= ENABLE_RST;
         phase_step_ff <= PHASE_STEP_RST;
         amplitude_ff  <= AMPLITUDE_RST;
         pan_ff        <= PAN_RST;
         wave_shape_ff <= WAVE_SHAPE_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ENABLE:     enable_ff     <= csr_write_data[0];
            CSR_PHASE_STEP: phase_step_ff <= csr_write_data[31:0];
            CSR_AMPLITUDE:  amplitude_ff  <= csr_write_data[15:0];
            CSR_PAN:        pan_ff        <= csr_write_data[15:0];
            CSR_WAVE_SHAPE: wave_shape_ff <= csr_write_data[2:0];
            default: ;
         endcase
      end
   end

   // Result register: it holds a finished frame until the transfer completes,
   // so the next frame can already be accepted behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && out_free) begin
         rsp_left_ff  <= sat16(sum_l);
         rsp_right_ff <= sat16(sum_r);
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_left  = rsp_left_ff;
   assign rsp_right = rsp_right_ff;
   assign rsp_last  = rsp_last_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff != S_IDLE)
      else $error("accepted frame did not leave the idle state");

   a_disabled_holds_phase: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !enable_ff) |=> $stable(phase_ff) && $stable(noise_seed_ff))
      else $error("phase or seed moved on a disabled frame");

   a_seed_only_on_noise: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(noise_seed_ff) |->
         $past(req_accept && enable_ff && wave_shape_ff == WAVE_NOISE))
      else $error("noise seed changed outside an enabled noise frame");

   a_product_from_digit: assert property (@(posedge clock) disable iff (reset)
      prod_vld_ff |-> $past(state_ff == S_DIGIT))
      else $error("product accumulated without a digit multiply");

   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result presented outside the output step");

endmodule
`default_nettype wire

/* tb/tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb: self-checking testbench for stereo_panned_oscillator_top
// Frames of a stereo mix go in through the request channel. A scoreboard
// predicts the mix plus the panned oscillator sample for every frame, and
// checks each result transfer against it in order. A directed part covers the
// field extremes and every wave shape. Many random register settings follow,
// most of them with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
   import spo_pkg::*;

   localparam int unsigned QUARTER      = 1 << SINE_TABLE_BITS_DEF;
   localparam int unsigned PAN_SHIFT    = 16 - SINE_TABLE_BITS_DEF;
   localparam longint      FULL_SCALE   = 64'sd32768;
   localparam logic [2:0]  WAVE_SILENT_MIN = WAVE_NOISE + 3'd1;
   localparam logic [2:0]  WAVE_SILENT_MAX = 3'd7;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          DRAIN_CYCLES = 20;
   localparam int          SETTINGS_N   = 24;
   localparam int          REPORT_LIMIT = 10;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic               last;
   } frame_type;

   // The scoreboard keeps its own copy of the registers, the phase and the
   // noise seed, and the frames that are still owed by the block.
   class mix_scoreboard;
      logic        enable;
      logic [31:0] phase_step;
      logic [15:0] amplitude;
      logic [15:0] pan;
      logic [2:0]  wave_shape;
      logic [31:0] phase_acc;
      logic [31:0] noise_seed;
      longint      quarter_sine [QUARTER+1];
      frame_type   expected_frames [$];
      int          errors;

      function new();
         logic [63:0] x;
         logic [63:0] x2;
         logic [63:0] term;
         logic [63:0] v;
         longint      sum;
         // Quarter-wave table from a Taylor series in Q30, rounded to Q1.15.
         for (int i = 0; i <= QUARTER; i++) begin
            x    = (64'(i) * HALF_PI_Q30) >> SINE_TABLE_BITS_DEF;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 8; k++) begin
               term = ((term * x2) >> 30) / 64'(4 * k * k + 2 * k);
               if (k % 2 == 1) begin
                  sum = sum - longint'(term);
               end else begin
                  sum = sum + longint'(term);
               end
            end
            if (sum < 0) begin
               sum = 0;
            end
            v = ((64'(sum) << 15) + (64'd1 << 29)) >> 30;
            quarter_sine[i] = (v > 64'd32768) ? FULL_SCALE : longint'(v);
         end
         enable     = ENABLE_RST;
         phase_step = PHASE_STEP_RST;
         amplitude  = AMPLITUDE_RST;
         pan        = PAN_RST;
         wave_shape = WAVE_SHAPE_RST;
         phase_acc  = '0;
         noise_seed = NOISE_SEED_RST;
         errors     = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] reg_index,
                              logic [CSR_DATA_W-1:0] data);
         case (reg_index)
            CSR_ENABLE:     enable     = data[0];
            CSR_PHASE_STEP: phase_step = data[31:0];
            CSR_AMPLITUDE:  amplitude  = data[15:0];
            CSR_PAN:        pan        = data[15:0];
            CSR_WAVE_SHAPE: wave_shape = data[2:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_frames.size();
      endfunction

      function longint wave_value(logic [31:0] u);
         logic [SINE_TABLE_BITS_DEF-1:0] idx;
         longint                         mag;
         case (wave_shape)
            WAVE_SINE: begin
               // The odd quadrants read the table backwards, the second half
               // of the cycle is negated.
               idx = u[29 -: SINE_TABLE_BITS_DEF];
               mag = u[30] ? quarter_sine[QUARTER - idx] : quarter_sine[idx];
               return u[31] ? -mag : mag;
            end
            WAVE_SQUARE:   return u[31] ? -FULL_SCALE : FULL_SCALE;
            WAVE_SAWTOOTH: return longint'(u >> 16) - FULL_SCALE;
            WAVE_TRIANGLE: begin
               if (u[31]) begin
                  return 3 * FULL_SCALE - longint'(u >> 15);
               end
               return longint'(u >> 15) - FULL_SCALE;
            end
            WAVE_NOISE: begin
               noise_seed ^= noise_seed << 13;
               noise_seed ^= noise_seed >> 17;
               noise_seed ^= noise_seed << 5;
               return longint'($signed(noise_seed[31:16]));
            end
            default: return 0;
         endcase
      endfunction

      // Round half up, dropping 30 of the 45 fraction bits, to Q1.15.
      function longint to_q15(longint v);
         return (v + (64'sd1 <<< 29)) >>> 30;
      endfunction

      function logic signed [15:0] saturate(longint v);
         if (v > 32767) begin
            return 16'sh7FFF;
         end
         if (v < -32768) begin
            return 16'sh8000;
         end
         return v[15:0];
      endfunction

      function void note_frame(logic signed [15:0] mix_l, logic signed [15:0] mix_r,
                               logic lst);
         frame_type   want;
         longint      s;
         longint      base;
         int unsigned pidx;
         want.left  = mix_l;
         want.right = mix_r;
         want.last  = lst;
         if (enable) begin
            s     = wave_value(phase_acc);
            base  = s * longint'(amplitude);
            pidx  = 32'((pan ^ 16'h8000) >> PAN_SHIFT);
            want.left  = saturate(longint'(mix_l) +
                                  to_q15(base * quarter_sine[QUARTER - pidx]));
            want.right = saturate(longint'(mix_r) + to_q15(base * quarter_sine[pidx]));
            phase_acc  = phase_acc + phase_step;
         end
         expected_frames.push_back(want);
      endfunction

      function void check_frame(logic signed [15:0] left, logic signed [15:0] right,
                                logic lst);
         frame_type want;
         if (expected_frames.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("unexpected result: left %0d right %0d last %0b",
                        left, right, lst);
            end
            return;
         end
         want = expected_frames.pop_front();
         if (left !== want.left || right !== want.right || lst !== want.last) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("mismatch: expected left %0d right %0d last %0b, got left %0d right %0d last %0b",
                        want.left, want.right, want.last, left, right, lst);
            end
         end
      endfunction
   endclass

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic signed [15:0]     req_mix_left     = '0;
   logic signed [15:0]     req_mix_right    = '0;
   logic                   req_block_last   = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic signed [15:0]     rsp_left;
   logic signed [15:0]     rsp_right;
   logic                   rsp_last;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data   = '0;

   // Percentages of cycles in which each side idles, set per phase of the run.
   int unsigned send_idle_pct = 29;
   int unsigned take_idle_pct = 45;
   // Raised once by the stimulus; the result side then holds off for a long
   // stretch so that the block backs up and stalls its input.
   bit          hold_request  = 1'b0;

   mix_scoreboard sb = new();

   stereo_panned_oscillator_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mix_left     (req_mix_left),
      .req_mix_right    (req_mix_right),
      .req_block_last   (req_block_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_left         (rsp_left),
      .rsp_right        (rsp_right),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // Result side. The stall is changed only at rising edges, and during a
   // hold-off it is left high without being driven again.
   initial begin : result_side
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < take_idle_pct);
      end
   end

   // A result transfer takes place at the next rising edge when valid is high
   // and stall is low. Both are stable at the falling edge, so the check is
   // made there and never races the edge itself.
   always @(negedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         sb.check_frame(rsp_left, rsp_right, rsp_last);
      end
   end

   // Offers one frame, with a random number of idle cycles in front of it,
   // and returns at the edge where the transfer happens. The payload is held
   // unchanged while the block stalls.
   task automatic send_frame(input logic signed [15:0] mix_l,
                             input logic signed [15:0] mix_r,
                             input logic lst);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mix_left   <= mix_l;
      req_mix_right  <= mix_r;
      req_block_last <= lst;
      do begin
         @(negedge clock);
         taken = (req_stall === 1'b0);
         @(posedge clock);
      end while (!taken);
      sb.note_frame(mix_l, mix_r, lst);
   endtask

   // Stops offering frames and waits until every owed result has arrived.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (sb.pending() != 0);
   endtask

   // One register write. The caller lowers the write enable after its last
   // write, so that back-to-back writes keep it high.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] reg_index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= reg_index;
      csr_write_data   <= data;
      @(posedge clock);
      sb.write_reg(reg_index, data);
   endtask

   task automatic apply_setting(input logic en, input logic [31:0] step,
                                input logic [15:0] amp, input logic [15:0] pan_pos,
                                input logic [2:0] shape);
      write_reg(CSR_ENABLE, {31'd0, en});
      write_reg(CSR_PHASE_STEP, step);
      write_reg(CSR_AMPLITUDE, {16'd0, amp});
      write_reg(CSR_PAN, {16'd0, pan_pos});
      write_reg(CSR_WAVE_SHAPE, {29'd0, shape});
      csr_write_enable <= 1'b0;
   endtask

   // A random subset of the registers gets new values, extremes often. The
   // unused upper bits of narrower writes carry noise, which the block must drop.
   task automatic random_setting();
      logic [CSR_DATA_W-1:0] data;
      if ($urandom_range(3) != 0) begin
         data    = $urandom;
         data[0] = ($urandom_range(5) != 0);
         write_reg(CSR_ENABLE, data);
      end
      if ($urandom_range(3) != 0) begin
         case ($urandom_range(7))
            0:       data = '0;
            1:       data = '1;
            2:       data = $urandom_range(65535);
            default: data = $urandom;
         endcase
         write_reg(CSR_PHASE_STEP, data);
      end
      if ($urandom_range(3) != 0) begin
         data = $urandom;
         case ($urandom_range(7))
            0:       data[15:0] = '0;
            1:       data[15:0] = 16'd32768;
            2:       data[15:0] = 16'hFFFF;
            3, 4:    data[15:0] = 16'($urandom_range(32768));
            default: ;
         endcase
         write_reg(CSR_AMPLITUDE, data);
      end
      if ($urandom_range(3) != 0) begin
         data = $urandom;
         case ($urandom_range(7))
            0:       data[15:0] = 16'h8000;
            1:       data[15:0] = 16'h7FFF;
            2:       data[15:0] = '0;
            default: ;
         endcase
         write_reg(CSR_PAN, data);
      end
      if ($urandom_range(3) != 0) begin
         data = $urandom;
         if ($urandom_range(7) == 0) begin
            data[2:0] = 3'($urandom_range(WAVE_SILENT_MAX, WAVE_SILENT_MIN));
         end else begin
            data[2:0] = 3'($urandom_range(WAVE_NOISE, WAVE_SINE));
         end
         write_reg(CSR_WAVE_SHAPE, data);
      end
      // Now and then a write to an index with no register behind it.
      if ($urandom_range(7) == 0) begin
         write_reg(CSR_INDEX_W'(CSR_WAVE_SHAPE + 1 + $urandom_range(1)), $urandom);
      end
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic signed [15:0] random_mix();
      case ($urandom_range(15))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return '0;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      int unsigned frames_n;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The first frames run on the register values after
      // reset, so the defaults and the zero phase are checked as well.
      send_frame(16'sd0, 16'sd0, 1'b0);
      send_frame(16'sh7FFF, 16'sh8000, 1'b1);
      send_frame(-16'sd1, 16'sd1, 1'b0);

      // Square at almost twice full gain, panned hard left: the sums saturate.
      wait_drained();
      apply_setting(1'b1, 32'h0123_4567, 16'hFFFF, 16'h8000, WAVE_SQUARE);
      send_frame(16'sh7FFF, 16'sh7FFF, 1'b1);
      send_frame(16'sh8000, 16'sh8000, 1'b0);
      send_frame(16'sd0, 16'sd0, 1'b1);

      // Zero amplitude, hard right, and a step that wraps the phase at once.
      wait_drained();
      apply_setting(1'b1, 32'hFFFF_FFFF, 16'd0, 16'h7FFF, WAVE_SAWTOOTH);
      send_frame(16'sh1234, -16'sh1234, 1'b0);
      send_frame(16'sh7FFF, 16'sh8000, 1'b1);

      // A quarter cycle per frame walks the triangle through every quadrant.
      wait_drained();
      apply_setting(1'b1, 32'h4000_0000, 16'd32768, 16'h0000, WAVE_TRIANGLE);
      repeat (4) send_frame(16'sd0, 16'sd0, 1'b0);

      wait_drained();
      apply_setting(1'b1, 32'h0800_0000, 16'd32768, 16'h4000, WAVE_SAWTOOTH);
      send_frame(16'sd0, 16'sd0, 1'b0);
      send_frame(16'sd100, -16'sd100, 1'b1);

      wait_drained();
      apply_setting(1'b1, 32'h0010_0000, 16'd32768, 16'hC000, WAVE_NOISE);
      repeat (3) send_frame(16'sd0, 16'sd0, 1'b0);

      // Disabled: the mix passes and the seed must not move.
      wait_drained();
      apply_setting(1'b0, 32'h0010_0000, 16'd32768, 16'hC000, WAVE_NOISE);
      send_frame(16'sh7FFF, 16'sh8000, 1'b1);
      send_frame(16'sh8000, 16'sh7FFF, 1'b0);

      wait_drained();
      apply_setting(1'b1, 32'h0010_0000, 16'd32768, 16'hC000, WAVE_NOISE);
      send_frame(16'sd0, 16'sd0, 1'b0);

      // Shape codes with no wave behind them add nothing but still advance.
      wait_drained();
      apply_setting(1'b1, 32'h1234_5678, 16'd32768, 16'h0000, WAVE_SILENT_MIN);
      send_frame(16'sd5, 16'sd7, 1'b0);
      wait_drained();
      apply_setting(1'b1, 32'h1234_5678, 16'd32768, 16'h0000, WAVE_SILENT_MAX);
      send_frame(16'sd5, 16'sd7, 1'b1);

      // A write beyond the register list must change nothing.
      wait_drained();
      write_reg(CSR_WAVE_SHAPE + 3'd3, 32'hFFFF_FFFF);
      csr_write_enable <= 1'b0;
      send_frame(16'sd0, 16'sd0, 1'b0);

      wait_drained();
      apply_setting(1'b1, 32'h8000_0000, 16'd32768, 16'h0000, WAVE_SINE);
      send_frame(16'sd0, 16'sd0, 1'b0);
      send_frame(16'sd0, 16'sd0, 1'b1);

      // Random part. The first third idles the sender less than the receiver,
      // the second the other way round, and the last has no idling at all.
      for (int setting_no = 0; setting_no < SETTINGS_N; setting_no++) begin
         if (setting_no < SETTINGS_N / 3) begin
            send_idle_pct = 29;
            take_idle_pct = 45;
         end else if (setting_no < 2 * SETTINGS_N / 3) begin
            send_idle_pct = 45;
            take_idle_pct = 29;
         end else begin
            send_idle_pct = 0;
            take_idle_pct = 0;
         end
         wait_drained();
         random_setting();
         frames_n = $urandom_range(70, 30);
         for (int i = 0; i < frames_n; i++) begin
            if (setting_no == 5 && i == 10) begin
               hold_request = 1'b1;
            end
            // The sender stops once in mid-stream until nothing is owed.
            if (setting_no == 13 && i == frames_n / 2) begin
               wait_drained();
            end
            send_frame(random_mix(), random_mix(), ($urandom_range(7) == 0));
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         $display("%0d results never arrived", sb.pending());
      end
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[stereo_panned_oscillator_top] OK");
      end else begin
         $display("[stereo_panned_oscillator_top] ERROR");
      end
      $finish;
   end

   // A run that hangs is ended here; a correct run needs far less time.
   initial begin : watchdog
      #1_000_000;
      $display("[stereo_panned_oscillator_top] ERROR");
      $finish;
   end

endmodule
`default_nettype wire
